/* hdl/bqdm_pkg.sv */
// ----------------------------------------------------------------------------
// Bounded queue package
// Shared types, codes and sizes for the bounded queue with search and delete.
// ----------------------------------------------------------------------------
package bqdm_pkg;

	// Widths fixed by the transaction fields, and the default memory depth.
	localparam int CNT_W   = 5;
	localparam int VAL_W   = 32;
	localparam int DEPTH_D = 16;

	// Command codes carried in the cmd field.
	typedef enum logic [1:0] {
		OP_PUSH   = 2'd0,
		OP_DELETE = 2'd1,
		OP_MAX    = 2'd2
	} opcode_t;

	// Result status codes.
	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_FULL      = 2'd1,
		ST_NOT_FOUND = 2'd2
	} status_t;

	// Controller states.
	typedef enum logic [1:0] {
		S_IDLE = 2'd0,
		S_SCAN = 2'd1,
		S_RESP = 2'd2
	} state_t;

	// Input transaction payload.
	typedef struct packed {
		logic [1:0]              cmd;
		logic signed [VAL_W-1:0] item_value;
	} in_item_t;

	// Output transaction payload.
	typedef struct packed {
		logic [1:0]              status;
		logic [CNT_W-1:0]        entry_count;
		logic signed [VAL_W-1:0] max_value;
	} out_item_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic scan_start;
		logic scan_en;
		logic commit;
	} ctl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic scan_done;
		logic out_busy;
	} dp_sts_t;

endpackage

/* hdl/bounded_queue_delete_max_top.sv */
// Push, max query and unused commands go straight from acceptance to the result state.
// Delete first walks the entry memory one read per cycle, then finishes the scan and reports.
// One transaction at a time; a new one is taken the cycle after the result is staged,
// and a held result delays the staging.
// Reset clears the count and the output valid and sets the limit to 16; entries are not cleared.
// ----------------------------------------------------------------------------
// Bounded queue with search and delete
// Top level joining the controller and the datapath with its entry memory.
// ----------------------------------------------------------------------------
module bounded_queue_delete_max_top
	import bqdm_pkg::*;
#(
	parameter int DEPTH = DEPTH_D
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [CNT_W-1:0] cfg_wdata,
	input  logic             in_valid,
	output logic             in_ready,
	input  in_item_t         in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output out_item_t        out_data
);

	ctl_cmd_t ctl;
	dp_sts_t  sts;

	bqdm_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_cmd  (in_data.cmd),
		.in_ready(in_ready),
		.sts     (sts),
		.ctl     (ctl)
	);

	bqdm_dp #(
		.DEPTH(DEPTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_data  (in_data),
		.ctl      (ctl),
		.sts      (sts),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

`ifndef NO_ASSERTIONS
	// A new result appears only after a commit from the controller.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(ctl.commit))
		else $error("result valid rose without a commit");

	// No transaction is taken while a delete scan is running.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !ctl.scan_en)
		else $error("input ready during scan");

	// The reported count never exceeds the memory depth.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.entry_count <= DEPTH))
		else $error("entry count above depth");
`endif

endmodule

/* hdl/bqdm_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// Simple dual-port memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
module bqdm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* hdl/bqdm_ctrl.sv */
// ----------------------------------------------------------------------------
// Bounded queue controller
// Sequences each transaction through the result phase, with a scan phase first for a delete.
// ----------------------------------------------------------------------------
module bqdm_ctrl
	import bqdm_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic [1:0] in_cmd,
	output logic       in_ready,
	input  dp_sts_t    sts,
	output ctl_cmd_t   ctl
);

	state_t state_q;
	state_t state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and command outputs.
	always_comb begin
		state_d  = state_q;
		ctl      = '0;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					ctl.load = 1'b1;
					if (in_cmd == OP_DELETE) begin
						ctl.scan_start = 1'b1;
						state_d        = S_SCAN;
					end else begin
						state_d = S_RESP;
					end
				end
			end
			S_SCAN: begin
				ctl.scan_en = 1'b1;
				if (sts.scan_done) begin
					state_d = S_RESP;
				end
			end
			S_RESP: begin
				if (!sts.out_busy) begin
					ctl.commit = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

/* hdl/bqdm_dp.sv */
// ----------------------------------------------------------------------------
// Bounded queue datapath
// Holds the count, the running maximum, the limit and the output register,
// and walks the entry memory during a delete.
// ----------------------------------------------------------------------------
module bqdm_dp
	import bqdm_pkg::*;
#(
	parameter int DEPTH = DEPTH_D
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [CNT_W-1:0] cfg_wdata,
	input  in_item_t         in_data,
	input  ctl_cmd_t         ctl,
	output dp_sts_t          sts,
	output logic             out_valid,
	input  logic             out_ready,
	output out_item_t        out_data
);

	localparam int AW  = $clog2(DEPTH);
	localparam int LIM = (DEPTH < 31) ? DEPTH : 31;

	logic [CNT_W-1:0]        cap_q;
	logic [CNT_W-1:0]        count_q;
	logic signed [VAL_W-1:0] max_q;
	logic [1:0]              op_q;
	logic signed [VAL_W-1:0] val_q;
	logic [CNT_W-1:0]        rd_ptr_q;
	logic                    vld_s1;
	logic [CNT_W-1:0]        idx_s1;
	logic                    found_q;
	logic                    have_best_q;
	logic signed [VAL_W-1:0] best_q;
	logic                    out_valid_q;
	out_item_t               out_q;

	logic [CNT_W-1:0]        limit;
	logic                    rd_en;
	logic signed [VAL_W-1:0] rdata;
	logic                    first_hit;
	logic                    shift_we;
	logic                    push_we;
	logic                    ram_we;
	logic [AW-1:0]           ram_waddr;
	logic [VAL_W-1:0]        ram_wdata;
	logic [1:0]              st;
	logic [CNT_W-1:0]        nxt_count;
	logic signed [VAL_W-1:0] nxt_max;

	// Effective limit is the smallest of the register, the depth and 31.
	assign limit = (cap_q < CNT_W'(LIM)) ? cap_q : CNT_W'(LIM);

	// Scan reads and the match on returned data.
	assign rd_en     = ctl.scan_en && (rd_ptr_q < count_q);
	assign first_hit = vld_s1 && !found_q && (rdata == val_q);
	assign shift_we  = vld_s1 && found_q;

	// Outcome of the held transaction.
	always_comb begin
		st        = ST_OK;
		nxt_count = count_q;
		nxt_max   = max_q;
		push_we   = 1'b0;
		case (op_q)
			OP_PUSH: begin
				if (count_q >= limit) begin
					st = ST_FULL;
				end else begin
					push_we   = 1'b1;
					nxt_count = count_q + CNT_W'(1);
					if (count_q == '0 || val_q > max_q) begin
						nxt_max = val_q;
					end
				end
			end
			OP_DELETE: begin
				if (found_q) begin
					nxt_count = count_q - CNT_W'(1);
					nxt_max   = best_q;
				end else begin
					st = ST_NOT_FOUND;
				end
			end
			default: begin
				st = ST_OK;
			end
		endcase
	end

	// Memory write selection: push appends, delete shifts toward the head.
	always_comb begin
		ram_we    = shift_we || (ctl.commit && push_we);
		ram_waddr = AW'(count_q);
		ram_wdata = val_q;
		if (shift_we) begin
			ram_waddr = AW'(idx_s1 - CNT_W'(1));
			ram_wdata = rdata;
		end
	end

	bqdm_ram #(
		.WIDTH(VAL_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (rd_en),
		.raddr(AW'(rd_ptr_q)),
		.rdata(rdata)
	);

	// Configuration, queue state and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q       <= CNT_W'(16);
			count_q     <= '0;
			vld_s1      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				cap_q <= cfg_wdata;
			end
			if (ctl.commit) begin
				count_q <= nxt_count;
			end
			vld_s1 <= rd_en;
			if (ctl.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Held transaction, scan accumulators and result payload.
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			op_q  <= in_data.cmd;
			val_q <= in_data.item_value;
		end
		if (ctl.scan_start) begin
			rd_ptr_q    <= '0;
			found_q     <= 1'b0;
			have_best_q <= 1'b0;
		end else begin
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + CNT_W'(1);
			end
			if (vld_s1) begin
				if (first_hit) begin
					found_q <= 1'b1;
				end else begin
					have_best_q <= 1'b1;
					if (!have_best_q || rdata > best_q) begin
						best_q <= rdata;
					end
				end
			end
		end
		if (rd_en) begin
			idx_s1 <= rd_ptr_q;
		end
		if (ctl.commit) begin
			max_q             <= nxt_max;
			out_q.status      <= st;
			out_q.entry_count <= nxt_count;
			out_q.max_value   <= (nxt_count == '0) ? '0 : nxt_max;
		end
	end

	assign sts.scan_done = (rd_ptr_q == count_q) && !vld_s1;
	assign sts.out_busy  = out_valid_q && !out_ready;
	assign out_valid     = out_valid_q;
	assign out_data      = out_q;

endmodule
